>>> rtl/besl_pkg.sv
package besl_pkg;

  // default saturation limit of the expression length counter
  localparam int unsigned MAX_EXPR_LEN_DEF = 65535;

  // request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOF  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_NEWLINE = 2'd1;
  localparam logic [1:0] KIND_EOF_IN  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  // bit positions of the pending look-ahead checks
  localparam int unsigned PEND_A  = 0;  // plain operator, needs a space next
  localparam int unsigned PEND_BG = 1;  // compare char, good left side
  localparam int unsigned PEND_BB = 2;  // compare char, bad left side
  localparam int unsigned PEND_B2 = 3;  // compare pair, needs a space next

  // saturation limits
  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam logic [31:0] MAX32 = 32'hFFFFFFFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [23:0] line_number;
    logic [15:0] expr_length;
    logic [15:0] expr_warnings;
    logic        quote_unterminated;
    logic [23:0] expr_total;
    logic [23:0] clean_total;
    logic [23:0] warn_total;
    logic [15:0] longest_length;
    logic [31:0] length_sum;
  } res_item_t;

  // item handed from the input register to the scan stage
  typedef struct packed {
    logic     en;
    in_item_t item;
  } step_t;

  // result handed from the scan stage to the output register
  typedef struct packed {
    logic      valid;
    res_item_t item;
  } res_t;

  function automatic logic is_plain_op(input logic [7:0] x);
    logic hit;
    case (x) inside
      CH_BAR, CH_AMP, CH_EQ, CH_PLUS, CH_MINUS,
      CH_STAR, CH_SLASH, CH_PCT, CH_QMARK, CH_COLON: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> rtl/besl_in_if.sv
interface besl_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

>>> rtl/besl_out_if.sv
interface besl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [23:0] line_number;
  logic [15:0] expr_length;
  logic [15:0] expr_warnings;
  logic        quote_unterminated;
  logic [23:0] expr_total;
  logic [23:0] clean_total;
  logic [23:0] warn_total;
  logic [15:0] longest_length;
  logic [31:0] length_sum;

  modport source (
    output valid, output result_kind, output line_number, output expr_length,
    output expr_warnings, output quote_unterminated, output expr_total,
    output clean_total, output warn_total, output longest_length, output length_sum,
    input ready
  );
  modport sink (
    input valid, input result_kind, input line_number, input expr_length,
    input expr_warnings, input quote_unterminated, input expr_total,
    input clean_total, input warn_total, input longest_length, input length_sum,
    output ready
  );
endinterface

>>> rtl/besl_in_stage.sv
module besl_in_stage
  import besl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     out_free,
  output step_t    step
);

  logic     valid_r;
  in_item_t item_r;

  // the held item moves on whenever the output register can take a result
  assign in_ready  = !valid_r || out_free;
  assign step.en   = valid_r && out_free;
  assign step.item = item_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/besl_scan.sv
module besl_scan
  import besl_pkg::*;
#(
  parameter int unsigned MAX_EXPR_LEN = MAX_EXPR_LEN_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  step_t step,
  output res_t  res
);

  localparam logic [15:0] LenMax = 16'(MAX_EXPR_LEN);

  typedef enum logic [1:0] {
    MODE_OUT  = 2'd0,
    MODE_IN   = 2'd1,
    MODE_HALT = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [7:0]  win_r, win_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic        quote_r, quote_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] wcnt_r, wcnt_nxt;
  logic [23:0] line_r, line_nxt;
  logic [23:0] expr_r, expr_nxt;
  logic [23:0] clean_r, clean_nxt;
  logic [23:0] warn_r, warn_nxt;
  logic [15:0] max_r, max_nxt;
  logic [31:0] sum_r, sum_nxt;

  logic [7:0]  x;
  logic        eof;
  logic        left_bad;
  logic        op_left;
  logic [2:0]  k_body;
  logic [2:0]  k_close;
  logic [16:0] wcnt_body_sum, wcnt_close_sum;
  logic [24:0] warn_body_sum, warn_close_sum;
  logic [15:0] wcnt_body, wcnt_close;
  logic [23:0] warn_body, warn_close;
  logic [32:0] sum_add;
  logic [15:0] depth_dec;
  logic        emit;
  logic [1:0]  kind;
  logic [15:0] rlen, rwrn;
  logic        rq;

  // warning counts of this byte, for a body byte and for the closing bracket
  always_comb begin
    x        = step.item.in_byte;
    eof      = (step.item.req_type == REQ_EOF);
    left_bad = (len_r != 16'd0) && (win_r != CH_SPACE);
    op_left  = !quote_r && (x != CH_QUOTE) && is_plain_op(x) && left_bad;
    k_body   = {2'b00, pend_r[PEND_B2] && (x != CH_SPACE)}
             + {2'b00, pend_r[PEND_A] && (x != CH_SPACE)}
             + {2'b00, pend_r[PEND_BB] && (x == CH_EQ)}
             + {2'b00, op_left};
    k_close  = {2'b00, pend_r[PEND_A]} + {2'b00, pend_r[PEND_B2]};

    wcnt_body_sum  = {1'b0, wcnt_r} + 17'(k_body);
    wcnt_close_sum = {1'b0, wcnt_r} + 17'(k_close);
    warn_body_sum  = {1'b0, warn_r} + 25'(k_body);
    warn_close_sum = {1'b0, warn_r} + 25'(k_close);
    wcnt_body  = wcnt_body_sum[16]  ? MAX16 : wcnt_body_sum[15:0];
    wcnt_close = wcnt_close_sum[16] ? MAX16 : wcnt_close_sum[15:0];
    warn_body  = warn_body_sum[24]  ? MAX24 : warn_body_sum[23:0];
    warn_close = warn_close_sum[24] ? MAX24 : warn_close_sum[23:0];

    sum_add   = {1'b0, sum_r} + {17'd0, len_r};
    depth_dec = (depth_r != 16'd0) ? depth_r - 16'd1 : depth_r;
  end

  // next state of the scanner
  always_comb begin
    mode_nxt  = mode_r;
    prev_nxt  = prev_r;
    depth_nxt = depth_r;
    win_nxt   = win_r;
    pend_nxt  = pend_r;
    quote_nxt = quote_r;
    len_nxt   = len_r;
    wcnt_nxt  = wcnt_r;
    line_nxt  = line_r;
    expr_nxt  = expr_r;
    clean_nxt = clean_r;
    warn_nxt  = warn_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    emit      = 1'b0;
    kind      = KIND_DONE;
    rlen      = 16'd0;
    rwrn      = 16'd0;
    rq        = 1'b0;

    unique case (mode_r)
      MODE_OUT: begin
        if (eof) begin
          emit     = 1'b1;
          kind     = KIND_SUMMARY;
          mode_nxt = MODE_HALT;
        end else begin
          if (x == CH_NL) begin
            if (line_r != MAX24) line_nxt = line_r + 24'd1;
          end else if (x == CH_LBRACK && prev_r == CH_DOLLAR) begin
            depth_nxt = 16'd1;
            win_nxt   = 8'd0;
            pend_nxt  = 4'd0;
            quote_nxt = 1'b0;
            len_nxt   = 16'd0;
            wcnt_nxt  = 16'd0;
            mode_nxt  = MODE_IN;
          end
          prev_nxt = x;
        end
      end
      MODE_IN: begin
        if (eof) begin
          emit     = 1'b1;
          kind     = KIND_EOF_IN;
          rlen     = len_r;
          mode_nxt = MODE_HALT;
        end else if (x == CH_NL) begin
          emit     = 1'b1;
          kind     = KIND_NEWLINE;
          rlen     = len_r;
          mode_nxt = MODE_HALT;
        end else if (x == CH_RBRACK && depth_dec == 16'd0) begin
          // matching bracket: the end counts as a non-space
          prev_nxt = x;
          emit     = 1'b1;
          kind     = KIND_DONE;
          rlen     = len_r;
          rwrn     = wcnt_close;
          rq       = quote_r;
          warn_nxt = warn_close;
          if (expr_r != MAX24) expr_nxt = expr_r + 24'd1;
          if (wcnt_close == 16'd0 && clean_r != MAX24) clean_nxt = clean_r + 24'd1;
          if (len_r > max_r) max_nxt = len_r;
          sum_nxt   = sum_add[32] ? MAX32 : sum_add[31:0];
          depth_nxt = 16'd0;
          win_nxt   = 8'd0;
          pend_nxt  = 4'd0;
          quote_nxt = 1'b0;
          len_nxt   = 16'd0;
          wcnt_nxt  = 16'd0;
          mode_nxt  = MODE_OUT;
        end else begin
          prev_nxt = x;
          if (x == CH_LBRACK) begin
            if (depth_r != MAX16) depth_nxt = depth_r + 16'd1;
          end else if (x == CH_RBRACK) begin
            depth_nxt = depth_dec;
          end
          // body byte: settle look-ahead, then check this byte
          wcnt_nxt = wcnt_body;
          warn_nxt = warn_body;
          pend_nxt = 4'd0;
          pend_nxt[PEND_B2] = pend_r[PEND_BG] && (x == CH_EQ);
          if (quote_r) begin
            if (x == CH_QUOTE) quote_nxt = 1'b0;
          end else if (x == CH_QUOTE) begin
            quote_nxt = 1'b1;
          end else if (is_plain_op(x)) begin
            if (!left_bad) pend_nxt[PEND_A] = 1'b1;
          end else if (x == CH_LT || x == CH_GT || x == CH_BANG) begin
            if (left_bad) pend_nxt[PEND_BB] = 1'b1;
            else          pend_nxt[PEND_BG] = 1'b1;
          end
          win_nxt = x;
          if (len_r < LenMax) len_nxt = len_r + 16'd1;
        end
      end
      default: begin
        // halted until reset
      end
    endcase
  end

  // result of this step, totals after the update
  always_comb begin
    res.valid                   = step.en && emit;
    res.item.result_kind        = kind;
    res.item.line_number        = line_nxt;
    res.item.expr_length        = rlen;
    res.item.expr_warnings      = rwrn;
    res.item.quote_unterminated = rq;
    res.item.expr_total         = expr_nxt;
    res.item.clean_total        = clean_nxt;
    res.item.warn_total         = warn_nxt;
    res.item.longest_length     = max_nxt;
    res.item.length_sum         = sum_nxt;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OUT;
      prev_r  <= 8'd0;
      depth_r <= 16'd0;
      win_r   <= 8'd0;
      pend_r  <= 4'd0;
      quote_r <= 1'b0;
      len_r   <= 16'd0;
      wcnt_r  <= 16'd0;
      line_r  <= 24'd1;
      expr_r  <= 24'd0;
      clean_r <= 24'd0;
      warn_r  <= 24'd0;
      max_r   <= 16'd0;
      sum_r   <= 32'd0;
    end else if (step.en) begin
      mode_r  <= mode_nxt;
      prev_r  <= prev_nxt;
      depth_r <= depth_nxt;
      win_r   <= win_nxt;
      pend_r  <= pend_nxt;
      quote_r <= quote_nxt;
      len_r   <= len_nxt;
      wcnt_r  <= wcnt_nxt;
      line_r  <= line_nxt;
      expr_r  <= expr_nxt;
      clean_r <= clean_nxt;
      warn_r  <= warn_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

>>> rtl/besl_out_stage.sv
module besl_out_stage
  import besl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_t      res,
  input  logic      out_ready,
  output logic      out_valid,
  output res_item_t out_item,
  output logic      out_free
);

  logic      valid_r;
  res_item_t item_r;

  // free when empty or when the held result transfers this cycle
  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      item_r <= res.item;
    end
  end

endmodule

>>> rtl/bracketed_expr_spacing_lint_unit.sv
// Path: a result passes from the input register through the combinational scanner into
// the output register, which holds it until it transfers.
// Throughput: one byte per cycle; the scanner computes its next state combinationally between
// the input register and the output register, stalled only by a held output.
// Reset: synchronous rst_n clears both register stages and the scanner state, with the
// line counter at one; no clearing pass, the block accepts bytes right after reset.
module bracketed_expr_spacing_lint_unit
  import besl_pkg::*;
#(
  parameter int unsigned MAX_EXPR_LEN = MAX_EXPR_LEN_DEF
) (
  input logic         clk,
  input logic         rst_n,
  besl_in_if.sink     in_ch,
  besl_out_if.source  out_ch
);

  in_item_t  in_item;
  step_t     step;
  res_t      res;
  res_item_t out_item;
  logic      out_free;

  assign in_item.req_type = in_ch.req_type;
  assign in_item.in_byte  = in_ch.in_byte;

  // input register
  besl_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .out_free (out_free),
    .step     (step)
  );

  // scanner
  besl_scan #(
    .MAX_EXPR_LEN (MAX_EXPR_LEN)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  // output register
  besl_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .out_free  (out_free)
  );

  assign out_ch.result_kind        = out_item.result_kind;
  assign out_ch.line_number        = out_item.line_number;
  assign out_ch.expr_length        = out_item.expr_length;
  assign out_ch.expr_warnings      = out_item.expr_warnings;
  assign out_ch.quote_unterminated = out_item.quote_unterminated;
  assign out_ch.expr_total         = out_item.expr_total;
  assign out_ch.clean_total        = out_item.clean_total;
  assign out_ch.warn_total         = out_item.warn_total;
  assign out_ch.longest_length     = out_item.longest_length;
  assign out_ch.length_sum         = out_item.length_sum;

  // a result comes only from an item that moves through the scanner
  a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> step.en)
    else $error("scan result without a step");

  // nothing follows an error or summary transfer
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.result_kind != KIND_DONE) |=> !out_ch.valid)
    else $error("result after halt");

  // clean expressions never outnumber expressions
  a_clean_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.clean_total <= out_ch.expr_total))
    else $error("clean total exceeds expression total");

  // length stays within its saturation limit
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.expr_length) <= 32'(MAX_EXPR_LEN)))
    else $error("expression length above limit");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import besl_pkg::*;

  // run length and pressure knobs
  localparam int unsigned RUN_LIMIT    = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_PRINTS   = 100;

  // in the directed text this marks a zero byte
  localparam logic [7:0] NUL_MARK = "^";

  typedef enum logic [1:0] {
    SCAN_OUT  = 2'd0,
    SCAN_IN   = 2'd1,
    SCAN_HALT = 2'd2
  } scan_mode_t;

  typedef enum int {
    END_SUMMARY,
    END_NEWLINE,
    END_EOF_IN
  } ending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  besl_in_if  in_ch ();
  besl_out_if out_ch ();

  bracketed_expr_spacing_lint_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scanner state mirrored by the predictor
  scan_mode_t  lint_mode;
  logic [7:0]  last_byte;
  logic [15:0] nest_depth;
  logic [7:0]  tail_byte;
  logic [3:0]  look_pend;
  logic        quote_open;
  logic [15:0] body_len;
  logic [15:0] body_warn;
  logic [23:0] line_no;
  logic [23:0] n_expr;
  logic [23:0] n_clean;
  logic [23:0] n_warn;
  logic [15:0] len_max;
  logic [31:0] len_sum;

  // reports still owed by the block, oldest first
  res_item_t   lint_reports_due[$];
  logic        typed_armed = 1'b0;
  res_item_t   typed_want;

  // directed rows: text, and a hand-typed report where one is obvious
  string       dir_text[$];
  bit          dir_typed[$];
  res_item_t   dir_want[$];

  int unsigned cyc = 0;
  int unsigned err_count = 0;
  int unsigned sent_items = 0;
  int unsigned n_checked = 0;
  int unsigned kind_seen[4];
  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  logic [7:0]  gen_prev = 8'h00;
  bit          hold_arm = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;
  ending_t     ending;

  function automatic void lint_add_warning();
    if (body_warn != MAX16) body_warn++;
    if (n_warn != MAX24) n_warn++;
  endfunction

  function automatic void lint_clear_body();
    nest_depth = '0;
    tail_byte  = '0;
    look_pend  = '0;
    quote_open = 1'b0;
    body_len   = '0;
    body_warn  = '0;
  endfunction

  function automatic res_item_t lint_report(input logic [1:0] kind, input logic [15:0] len,
                                            input logic [15:0] warns, input logic q);
    res_item_t r;
    r.result_kind        = kind;
    r.line_number        = line_no;
    r.expr_length        = len;
    r.expr_warnings      = warns;
    r.quote_unterminated = q;
    r.expr_total         = n_expr;
    r.clean_total        = n_clean;
    r.warn_total         = n_warn;
    r.longest_length     = len_max;
    r.length_sum         = len_sum;
    return r;
  endfunction

  function automatic void lint_reset();
    lint_mode = SCAN_OUT;
    last_byte = '0;
    lint_clear_body();
    line_no = 24'd1;
    n_expr  = '0;
    n_clean = '0;
    n_warn  = '0;
    len_max = '0;
    len_sum = '0;
  endfunction

  // advance the scanner by one transfer, returns 1 when a report is due
  function automatic bit lint_scan_item(input logic req, input logic [7:0] b,
                                        output res_item_t rep);
    logic [3:0]  nxt;
    logic        left_bad;
    logic [32:0] sum_wide;
    nxt = '0;
    rep = '0;
    left_bad = (body_len != 0) && (tail_byte != CH_SPACE);

    // outside any expression: count lines, look for the opening pair
    if (lint_mode == SCAN_OUT) begin
      if (req == REQ_EOF) begin
        rep = lint_report(KIND_SUMMARY, '0, '0, 1'b0);
        lint_mode = SCAN_HALT;
        return 1'b1;
      end
      if (b == CH_NL) begin
        if (line_no != MAX24) line_no++;
      end else if (b == CH_LBRACK && last_byte == CH_DOLLAR) begin
        lint_clear_body();
        nest_depth = 16'd1;
        lint_mode = SCAN_IN;
      end
      last_byte = b;
      return 1'b0;
    end
    if (lint_mode != SCAN_IN) return 1'b0;

    // errors inside an expression halt the scanner
    if (req == REQ_EOF) begin
      rep = lint_report(KIND_EOF_IN, body_len, '0, 1'b0);
      lint_mode = SCAN_HALT;
      return 1'b1;
    end
    if (b == CH_NL) begin
      rep = lint_report(KIND_NEWLINE, body_len, '0, 1'b0);
      lint_mode = SCAN_HALT;
      return 1'b1;
    end
    last_byte = b;

    // bracket nesting, the matching close ends the expression
    if (b == CH_LBRACK) begin
      if (nest_depth != MAX16) nest_depth++;
    end else if (b == CH_RBRACK) begin
      if (nest_depth != 0) nest_depth--;
      if (nest_depth == 0) begin
        if (look_pend[PEND_A]) lint_add_warning();
        if (look_pend[PEND_B2]) lint_add_warning();
        if (n_expr != MAX24) n_expr++;
        if (body_warn == 0 && n_clean != MAX24) n_clean++;
        if (body_len > len_max) len_max = body_len;
        sum_wide = {1'b0, len_sum} + {17'd0, body_len};
        len_sum = sum_wide[32] ? MAX32 : sum_wide[31:0];
        rep = lint_report(KIND_DONE, body_len, body_warn, quote_open);
        lint_clear_body();
        lint_mode = SCAN_OUT;
        return 1'b1;
      end
    end

    // settle checks waiting on this byte
    if (look_pend[PEND_B2] && b != CH_SPACE) lint_add_warning();
    if (look_pend[PEND_A] && b != CH_SPACE) lint_add_warning();
    if (look_pend[PEND_BB] && b == CH_EQ) lint_add_warning();
    if (look_pend[PEND_BG] && b == CH_EQ) nxt[PEND_B2] = 1'b1;

    // quotes, then operators of this byte
    if (quote_open) begin
      if (b == CH_QUOTE) quote_open = 1'b0;
    end else if (b == CH_QUOTE) begin
      quote_open = 1'b1;
    end else if (b inside {CH_BAR, CH_AMP, CH_EQ, CH_PLUS, CH_MINUS,
                           CH_STAR, CH_SLASH, CH_PCT, CH_QMARK, CH_COLON}) begin
      if (left_bad) lint_add_warning();
      else nxt[PEND_A] = 1'b1;
    end else if (b inside {CH_LT, CH_GT, CH_BANG}) begin
      if (left_bad) nxt[PEND_BB] = 1'b1;
      else nxt[PEND_BG] = 1'b1;
    end
    look_pend = nxt;
    tail_byte = b;
    if (body_len < MAX_EXPR_LEN_DEF) body_len++;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("tb_top: cycle %0d: %s", cyc, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // compare result transfers, then predict from input transfers
  always @(posedge clk) begin : scoreboard
    res_item_t got;
    res_item_t want;
    res_item_t rep;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind        = out_ch.result_kind;
        got.line_number        = out_ch.line_number;
        got.expr_length        = out_ch.expr_length;
        got.expr_warnings      = out_ch.expr_warnings;
        got.quote_unterminated = out_ch.quote_unterminated;
        got.expr_total         = out_ch.expr_total;
        got.clean_total        = out_ch.clean_total;
        got.warn_total         = out_ch.warn_total;
        got.longest_length     = out_ch.longest_length;
        got.length_sum         = out_ch.length_sum;
        n_checked++;
        if (!$isunknown(got.result_kind)) kind_seen[got.result_kind]++;
        if (lint_reports_due.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = lint_reports_due.pop_front();
          check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
          check_field("line_number", 32'(got.line_number), 32'(want.line_number));
          check_field("expr_length", 32'(got.expr_length), 32'(want.expr_length));
          check_field("expr_warnings", 32'(got.expr_warnings), 32'(want.expr_warnings));
          check_field("quote_unterminated", 32'(got.quote_unterminated),
                      32'(want.quote_unterminated));
          check_field("expr_total", 32'(got.expr_total), 32'(want.expr_total));
          check_field("clean_total", 32'(got.clean_total), 32'(want.clean_total));
          check_field("warn_total", 32'(got.warn_total), 32'(want.warn_total));
          check_field("longest_length", 32'(got.longest_length),
                      32'(want.longest_length));
          check_field("length_sum", got.length_sum, want.length_sum);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (lint_scan_item(in_ch.req_type, in_ch.in_byte, rep)) begin
          if (typed_armed) begin
            rep = typed_want;
            typed_armed = 1'b0;
          end
          lint_reports_due.push_back(rep);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when armed
  always @(negedge clk) begin
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc > RUN_LIMIT) begin
      $display("tb_top: timeout with %0d reports outstanding", lint_reports_due.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // operator characters: plain ones first, then the compare leaders
  function automatic logic [7:0] op_char(input int unsigned idx);
    logic [7:0] c;
    case (idx)
      0:       c = CH_BAR;
      1:       c = CH_AMP;
      2:       c = CH_EQ;
      3:       c = CH_PLUS;
      4:       c = CH_MINUS;
      5:       c = CH_STAR;
      6:       c = CH_SLASH;
      7:       c = CH_PCT;
      8:       c = CH_QMARK;
      9:       c = CH_COLON;
      10:      c = CH_LT;
      11:      c = CH_GT;
      default: c = CH_BANG;
    endcase
    return c;
  endfunction

  // one transfer on the input channel, called and returning at a falling edge
  task automatic push_item(input logic req, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.in_byte  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(REQ_BYTE, b);
    gen_prev = b;
  endtask

  task automatic send_text(input string s);
    logic [7:0] b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      if (b == NUL_MARK) b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic add_row(input string s, input bit typed, input res_item_t want);
    dir_text.push_back(s);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  // expression body with random content, always closed before returning
  task automatic gen_body();
    int unsigned len;
    int          depth;
    logic [7:0]  b;
    len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 14);
    depth = 1;
    for (int k = 0; k < len && depth > 0; k++) begin
      case ($urandom_range(15))
        0, 1, 2: b = CH_SPACE;
        3, 4:    b = op_char($urandom_range(0, 9));
        5:       b = op_char($urandom_range(10, 12));
        6:       b = CH_EQ;
        7:       b = CH_QUOTE;
        8:       b = CH_LBRACK;
        9:       b = CH_RBRACK;
        10: begin
          // well spaced operator
          send_byte(CH_SPACE);
          send_byte(op_char($urandom_range(0, 12)));
          b = CH_SPACE;
        end
        11, 12:  b = 8'(8'h61 + $urandom_range(0, 25));
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == CH_NL) b = CH_SPACE;
      if (b == CH_LBRACK) depth++;
      else if (b == CH_RBRACK) depth--;
      send_byte(b);
    end
    while (depth > 0) begin
      send_byte(CH_RBRACK);
      depth--;
    end
  endtask

  // outside text, an expression most of the time, otherwise a broken opener
  task automatic gen_chunk();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(0, 6);
    repeat (n) begin
      b = ($urandom_range(4) == 0) ? CH_NL : 8'($urandom_range(0, 255));
      if (gen_prev == CH_DOLLAR && b == CH_LBRACK) b = CH_SPACE;
      send_byte(b);
    end
    if ($urandom_range(99) < 80) begin
      send_text("$[");
      gen_body();
    end else begin
      case ($urandom_range(3))
        0:       send_text("$ [");
        1:       send_text("[]]");
        2:       send_text("$x[");
        default: send_text("$$");
      endcase
    end
  endtask

  task automatic idle_until_drained();
    in_ch.valid <= 1'b0;
    while (lint_reports_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.in_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    lint_reset();

    // directed rows
    add_row("$[a]", 1'b1,
            '{KIND_DONE, 24'd1, 16'd1, 16'd0, 1'b0, 24'd1, 24'd1, 24'd0, 16'd1, 32'd1});
    add_row("\n$[]", 1'b1,
            '{KIND_DONE, 24'd2, 16'd0, 16'd0, 1'b0, 24'd2, 24'd2, 24'd0, 16'd1, 32'd1});
    add_row("$[|&=+-*/%?:]", 1'b0, '0);
    add_row("$[a<=b >=c != d]", 1'b0, '0);
    add_row("$[1 + ^\377 - x *]", 1'b0, '0);
    add_row("$[p <=]", 1'b0, '0);
    add_row("$[\"+\"[\"]]", 1'b0, '0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle = 9;
    rx_idle = 66;
    foreach (dir_text[i]) begin
      if (dir_typed[i]) begin
        typed_want  = dir_want[i];
        typed_armed = 1'b1;
      end
      send_text(dir_text[i]);
    end

    // random text, sender mostly busy, receiver mostly stalled
    while (sent_items < 300) gen_chunk();

    // long receiver hold-off while short expressions keep coming
    hold_arm = 1'b1;
    tx_idle = 0;
    repeat (80) send_text("$[a]");
    tx_idle = 9;
    while (sent_items < 650) gen_chunk();

    // roles swapped, with one full drain in the middle
    tx_idle = 66;
    rx_idle = 9;
    while (sent_items < 850) gen_chunk();
    idle_until_drained();
    while (sent_items < 1050) gen_chunk();

    // back to back to the end of the text
    tx_idle = 0;
    rx_idle = 0;
    while (sent_items < 1090) gen_chunk();

    // one terminating event, then input that must be ignored
    ending = ending_t'($urandom_range(0, 2));
    case (ending)
      END_SUMMARY: push_item(REQ_EOF, 8'($urandom_range(0, 255)));
      END_NEWLINE: begin
        send_text("$[a");
        send_byte(CH_NL);
      end
      default: begin
        send_text("$[a ");
        push_item(REQ_EOF, 8'($urandom_range(0, 255)));
      end
    endcase
    send_text("$[b]\n");
    push_item(REQ_EOF, 8'hFF);
    in_ch.valid <= 1'b0;

    while (lint_reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb_top: %0d bytes and end marks sent, %0d reports checked", sent_items,
             n_checked);
    $display("tb_top: done %0d, newline %0d, eof inside %0d, summary %0d, stop by %s",
             kind_seen[KIND_DONE], kind_seen[KIND_NEWLINE], kind_seen[KIND_EOF_IN],
             kind_seen[KIND_SUMMARY], ending.name());
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
